### hw/rtl/rc4_pkg.sv
// ----------------------------------------------------------------------------
// rc4_pkg
// shared types, codes and constants of the rc4 stream cipher
// ----------------------------------------------------------------------------
package rc4_pkg;

    // sizes
    localparam int KEY_DEPTH_DEF = 256;
    localparam int PERM_DEPTH    = 256;
    localparam int BYTE_W        = 8;
    localparam int KEY_LEN_W     = 9;
    localparam int APB_ADDR_W    = 3;
    localparam int APB_DATA_W    = 32;
    localparam int REG_IDX_W     = APB_ADDR_W - 2;

    localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = 9'd16;

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_KEY_LEN = 1'b0;

    // transaction modes
    localparam logic [1:0] MODE_LOAD_KEY = 2'd0;
    localparam logic [1:0] MODE_SCHEDULE = 2'd1;
    localparam logic [1:0] MODE_CIPHER   = 2'd2;

    // one input transaction
    typedef struct packed {
        logic [1:0]        mode;
        logic [BYTE_W-1:0] key_index;
        logic [BYTE_W-1:0] byte_value;
    } rc4_req_t;

    // engine sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_KS_RD_I,
        ST_KS_RD_J,
        ST_KS_WR_I,
        ST_KS_WR_J,
        ST_PR_RD_I,
        ST_PR_RD_J,
        ST_PR_WR_I,
        ST_PR_WR_J,
        ST_PR_RD_T,
        ST_PR_OUT
    } eng_state_t;

endpackage

### hw/rtl/rc4_engine.sv
// ----------------------------------------------------------------------------
// rc4_engine
// permutation and key store memories with the schedule and generator sequencer
// ----------------------------------------------------------------------------
module rc4_engine #(
    parameter int KEY_DEPTH = rc4_pkg::KEY_DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [rc4_pkg::KEY_LEN_W-1:0]  key_len,
    input  logic                           req_valid,
    input  rc4_pkg::rc4_req_t              req,
    output logic                           req_ready,
    output logic                           res_valid,
    output logic [rc4_pkg::BYTE_W-1:0]     res_data,
    input  logic                           res_ready
);
    import rc4_pkg::*;

    localparam int KW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;

    logic [BYTE_W-1:0] perm_mem [PERM_DEPTH];
    logic [BYTE_W-1:0] key_mem  [KEY_DEPTH];

    eng_state_t state_reg, state_next;
    logic [BYTE_W-1:0] i_reg, i_next;
    logic [BYTE_W-1:0] j_reg, j_next;
    logic [KW-1:0]     kpos_reg, kpos_next;
    logic [BYTE_W-1:0] si_reg, si_next;
    logic [BYTE_W-1:0] sj_reg, sj_next;
    logic [BYTE_W-1:0] byte_reg, byte_next;
    logic              sched_reg, sched_next;
    logic [BYTE_W-1:0] perm_q_reg;
    logic [BYTE_W-1:0] key_q_reg;

    logic              fire;
    logic              perm_we, perm_re;
    logic [BYTE_W-1:0] perm_addr, perm_wdata;
    logic              key_we, key_re;
    logic              key_in_range;
    logic [BYTE_W-1:0] key_add;
    logic [BYTE_W-1:0] j_sum;
    logic [KEY_LEN_W-1:0] len_m1;
    logic [KW-1:0]     kpos_wrap;

    assign fire         = req_valid && (state_reg == ST_IDLE);
    assign key_in_range = ({1'b0, req.key_index} < KEY_LEN_W'(KEY_DEPTH));

    // effective key length minus one, clamped to 1..KEY_DEPTH
    always_comb
    begin
        if (key_len == '0)
            len_m1 = '0;
        else if (key_len > KEY_LEN_W'(KEY_DEPTH))
            len_m1 = KEY_LEN_W'(KEY_DEPTH - 1);
        else
            len_m1 = key_len - KEY_LEN_W'(1);
    end

    assign kpos_wrap = (KEY_LEN_W'(kpos_reg) == len_m1) ? '0 : kpos_reg + KW'(1);
    assign key_add   = (state_reg == ST_KS_RD_J) ? key_q_reg : '0;
    assign j_sum     = j_reg + perm_q_reg + key_add;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (fire)
                begin
                    case (req.mode)
                        MODE_SCHEDULE: state_next = ST_INIT;
                        MODE_CIPHER:   state_next = sched_reg ? ST_PR_RD_I : ST_IDLE;
                        default:       state_next = ST_IDLE;
                    endcase
                end
            end
            ST_INIT:    state_next = (i_reg == '1) ? ST_KS_RD_I : ST_INIT;
            ST_KS_RD_I: state_next = ST_KS_RD_J;
            ST_KS_RD_J: state_next = ST_KS_WR_I;
            ST_KS_WR_I: state_next = ST_KS_WR_J;
            ST_KS_WR_J: state_next = (i_reg == '1) ? ST_IDLE : ST_KS_RD_I;
            ST_PR_RD_I: state_next = ST_PR_RD_J;
            ST_PR_RD_J: state_next = ST_PR_WR_I;
            ST_PR_WR_I: state_next = ST_PR_WR_J;
            ST_PR_WR_J: state_next = ST_PR_RD_T;
            ST_PR_RD_T: state_next = ST_PR_OUT;
            ST_PR_OUT:  state_next = res_ready ? ST_IDLE : ST_PR_OUT;
            default:    state_next = ST_IDLE;
        endcase
    end

    // outputs and memory controls
    always_comb
    begin
        req_ready  = 1'b0;
        res_valid  = 1'b0;
        perm_we    = 1'b0;
        perm_re    = 1'b0;
        perm_addr  = i_reg;
        perm_wdata = perm_q_reg;
        key_we     = 1'b0;
        key_re     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                key_we    = fire && (req.mode == MODE_LOAD_KEY) && key_in_range;
            end
            ST_INIT:
            begin
                perm_we    = 1'b1;
                perm_wdata = i_reg;
            end
            ST_KS_RD_I:
            begin
                perm_re = 1'b1;
                key_re  = 1'b1;
            end
            ST_KS_RD_J, ST_PR_RD_J:
            begin
                perm_re   = 1'b1;
                perm_addr = j_sum;
            end
            ST_KS_WR_I, ST_PR_WR_I:
            begin
                perm_we = 1'b1;
            end
            ST_KS_WR_J, ST_PR_WR_J:
            begin
                perm_we    = 1'b1;
                perm_addr  = j_reg;
                perm_wdata = si_reg;
            end
            ST_PR_RD_I:
            begin
                perm_re = 1'b1;
            end
            ST_PR_RD_T:
            begin
                perm_re   = 1'b1;
                perm_addr = si_reg + sj_reg;
            end
            ST_PR_OUT:
            begin
                res_valid = 1'b1;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

    assign res_data = perm_q_reg ^ byte_reg;

    // datapath register updates
    always_comb
    begin
        i_next     = i_reg;
        j_next     = j_reg;
        kpos_next  = kpos_reg;
        si_next    = si_reg;
        sj_next    = sj_reg;
        byte_next  = byte_reg;
        sched_next = sched_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (fire)
                begin
                    byte_next = req.byte_value;
                    case (req.mode)
                        MODE_SCHEDULE:
                        begin
                            i_next    = '0;
                            j_next    = '0;
                            kpos_next = '0;
                        end
                        MODE_CIPHER:
                        begin
                            if (sched_reg)
                                i_next = i_reg + 8'd1;
                        end
                        default:
                        begin
                            i_next = i_reg;
                        end
                    endcase
                end
            end
            ST_INIT:
            begin
                i_next = i_reg + 8'd1;
            end
            ST_KS_RD_J, ST_PR_RD_J:
            begin
                j_next  = j_sum;
                si_next = perm_q_reg;
            end
            ST_PR_WR_I:
            begin
                sj_next = perm_q_reg;
            end
            ST_KS_WR_J:
            begin
                i_next    = i_reg + 8'd1;
                kpos_next = kpos_wrap;
                if (i_reg == '1)
                begin
                    j_next     = '0;
                    sched_next = 1'b1;
                end
            end
            default:
            begin
                i_next = i_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            kpos_reg  <= '0;
            sched_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            kpos_reg  <= kpos_next;
            sched_reg <= sched_next;
        end
    end

    always_ff @(posedge clk)
    begin
        si_reg   <= si_next;
        sj_reg   <= sj_next;
        byte_reg <= byte_next;
    end

    // permutation memory, single port
    always_ff @(posedge clk)
    begin
        if (perm_we)
            perm_mem[perm_addr] <= perm_wdata;
        else if (perm_re)
            perm_q_reg <= perm_mem[perm_addr];
    end

    // key store, single port
    always_ff @(posedge clk)
    begin
        if (key_we)
            key_mem[req.key_index[KW-1:0]] <= req.byte_value;
        else if (key_re)
            key_q_reg <= key_mem[kpos_reg];
    end

    // checks
    a_perm_port: assert property (@(posedge clk) disable iff (!rst_n)
        !(perm_we && perm_re))
        else $error("permutation memory read and written in one cycle");

    a_sched_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_KS_WR_J) && (i_reg == '1)
        |=> (i_reg == '0) && (j_reg == '0) && sched_reg && (state_reg == ST_IDLE))
        else $error("indices not cleared at end of key schedule");

    a_no_data_unsched: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (req.mode == MODE_CIPHER) && !sched_reg |=> (state_reg == ST_IDLE))
        else $error("data transaction started before any key schedule");

    a_result_sched: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> sched_reg)
        else $error("result without a key schedule");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_data))
        else $error("pending result lost or changed");

endmodule

### hw/rtl/rc4_stream_cipher.sv
// ----------------------------------------------------------------------------
// rc4_stream_cipher
// rc4 stream cipher with key store, key schedule and keystream generator
// ----------------------------------------------------------------------------
// timing: a key byte is written to the key store as it is accepted; a key schedule
//   keeps the input stalled through 256 identity writes, then 4 permutation memory
//   accesses for each of 256 entries; a data byte appears on out_valid after the
//   states read s[i], read s[j], write s[i], write s[j], read s[s[i]+s[j]] and the
//   result handoff, and the next transaction is taken in the same cycle
// pacing: the engine takes no new data byte until the last one is handed off; each
//   needs five accesses on the single-port permutation memory plus the handoff
// reset: control state and indices clear, the key length returns to 16 and data
//   transactions are dropped until a key schedule; the memories are not cleared
// ----------------------------------------------------------------------------
module rc4_stream_cipher #(
    parameter int KEY_DEPTH = rc4_pkg::KEY_DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,

    // apb configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rc4_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [rc4_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [rc4_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,

    // input transactions
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [1:0]                      mode,
    input  logic [rc4_pkg::BYTE_W-1:0]      key_index,
    input  logic [rc4_pkg::BYTE_W-1:0]      byte_value,

    // result transactions
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [rc4_pkg::BYTE_W-1:0]      data_out
);
    import rc4_pkg::*;

    logic [KEY_LEN_W-1:0] key_len_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 cfg_write;

    rc4_req_t          req;
    logic              req_ready;
    logic              res_valid;
    logic              res_ready;
    logic [BYTE_W-1:0] res_data;

    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] data_out_reg;

    // ---------------- configuration ----------------
    // word address picks the register; anything past the list reads as zero
    assign reg_idx   = paddr[APB_ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_comb
    begin
        prdata = '0;
        if (reg_idx == REG_KEY_LEN)
            prdata = APB_DATA_W'(key_len_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            key_len_reg <= KEY_LEN_RESET;
        else if (cfg_write && (reg_idx == REG_KEY_LEN))
            key_len_reg <= pwdata[KEY_LEN_W-1:0];
    end

    // ---------------- engine ----------------
    // the engine takes a transaction only while idle; its result waits in the
    // output register so a new transaction can start while it is unclaimed
    assign req.mode       = mode;
    assign req.key_index  = key_index;
    assign req.byte_value = byte_value;
    assign in_stall       = !req_ready;

    rc4_engine #(
        .KEY_DEPTH (KEY_DEPTH)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .key_len    (key_len_reg),
        .req_valid  (in_valid),
        .req        (req),
        .req_ready  (req_ready),
        .res_valid  (res_valid),
        .res_data   (res_data),
        .res_ready  (res_ready)
    );

    // ---------------- output register ----------------
    // free when empty or being drained in this cycle
    assign res_ready = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid && res_ready)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // payload only, no reset
    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
            data_out_reg <= res_data;
    end

    assign out_valid = out_valid_reg;
    assign data_out  = data_out_reg;

endmodule
